/* hdl/assert_macros.svh */
// assertion helpers used by hfla_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant checked at every rising clock edge out of reset
`define HFLA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// same-cycle implication
`define HFLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// next-cycle implication
`define HFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* hdl/hfla_pkg.sv */
package hfla_pkg;

    localparam int POOL_SIZE = 256;
    localparam int IW        = $clog2(POOL_SIZE);
    localparam int LW        = $clog2(POOL_SIZE + 1);
    localparam int EW        = LW + 1;
    localparam int HIN_W     = 8;
    localparam int HOUT_W    = 9;
    localparam int CNT_W     = 9;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef logic [IW-1:0] t_idx;
    typedef logic [LW-1:0] t_link;

    typedef struct packed {
        logic  in_use;
        t_link link;
    } t_entry;

    typedef struct packed {
        logic   re;
        t_idx   raddr;
        logic   we;
        t_idx   waddr;
        t_entry wdata;
    } t_mem_req;

    localparam t_link END_MARK = t_link'(POOL_SIZE);

endpackage

/* hdl/hfla_if.sv */
interface hfla_req_if
    import hfla_pkg::*;
();
    logic             valid;
    logic             ready;
    t_op              op;
    logic [HIN_W-1:0] handle_in;

    modport source (output valid, output op, output handle_in, input ready);
    modport sink   (input valid, input op, input handle_in, output ready);
endinterface

interface hfla_rsp_if
    import hfla_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HOUT_W-1:0] handle_out;
    t_status           status;
    logic [CNT_W-1:0]  used_count;

    modport source (output valid, output handle_out, output status, output used_count,
                    input ready);
    modport sink   (input valid, input handle_out, input status, input used_count,
                    output ready);
endinterface

/* hdl/handle_free_list_allocator.sv */
// handle allocator: lifo free list of POOL_SIZE handles kept in one synchronous ram
// i_req  : op (allocate or free) and handle_in, valid/ready
// o_rsp  : handle_out, status and used_count, valid/ready, one per request
// each ram entry holds the link to the next free handle and the in-use bit
// a request transaction runs through S_IDLE, which reads the ram entry at the
// free-list head (allocate) or at handle_in (free), and S_EXEC, which checks it,
// writes it back if the request succeeds and loads the response register
// the response register is loaded as the block leaves S_EXEC
// a new request is taken only back in S_IDLE, after the ram read-modify-write
// a pending response does not block the next request transaction; the block
// waits in S_EXEC only while the response register is still full
// and unaccepted, holding i_req.ready low meanwhile
// reset: synchronous, active low; the list starts as 0, 1, 2 and so on with no
// handle in use; per-entry written flags stand in for the ram contents so no
// clearing pass is needed and requests are taken straight after reset
module handle_free_list_allocator
    import hfla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hfla_req_if.sink   i_req,
    hfla_rsp_if.source o_rsp
);
    t_mem_req w_mem;
    t_entry   w_rdata;

    hfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (w_mem),
        .i_rdata (w_rdata)
    );

    hfla_ram #(
        .DEPTH (POOL_SIZE),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );
endmodule

/* hdl/hfla_ram.sv */
module hfla_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/hfla_ctrl.sv */
`include "assert_macros.svh"

module hfla_ctrl
    import hfla_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hfla_req_if.sink      i_req,
    hfla_rsp_if.source    o_rsp,
    output t_mem_req      o_mem,
    input  t_entry        i_rdata
);
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state            r_state, n_state;
    t_link             r_head, n_head;
    t_link             r_count, n_count;
    logic              r_rsp_valid, n_rsp_valid;
    logic [HOUT_W-1:0] r_rsp_handle, n_rsp_handle;
    t_status           r_rsp_status, n_rsp_status;
    logic [CNT_W-1:0]  r_rsp_count, n_rsp_count;
    t_op               r_op, n_op;
    logic              r_range, n_range;
    t_idx              r_raddr, n_raddr;
    logic              r_vld;
    logic [POOL_SIZE-1:0] r_written;
    t_entry            w_entry;
    t_mem_req          w_mem;

    // entries never written read as their reset link, the next index, not in use
    assign w_entry = r_vld ? i_rdata : t_entry'({1'b0, t_link'(r_raddr) + t_link'(1)});

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_handle = r_rsp_handle;
        n_rsp_status = r_rsp_status;
        n_rsp_count  = r_rsp_count;
        n_op         = r_op;
        n_range      = r_range;
        n_raddr      = r_raddr;
        w_mem        = '0;
        i_req.ready  = (r_state == S_IDLE);

        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_range = (int'(i_req.handle_in) >= POOL_SIZE);
                    n_raddr = (i_req.op == OP_ALLOC) ? t_idx'(r_head)
                                                     : t_idx'(i_req.handle_in);
                    w_mem.re    = 1'b1;
                    w_mem.raddr = n_raddr;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_state      = S_IDLE;
                    n_rsp_valid  = 1'b1;
                    n_rsp_handle = HOUT_W'(END_MARK);
                    n_rsp_status = ST_OK;
                    if (r_op == OP_ALLOC) begin
                        if (r_head == END_MARK) begin
                            n_rsp_status = ST_EMPTY;
                        end else begin
                            w_mem.we     = 1'b1;
                            w_mem.waddr  = r_raddr;
                            w_mem.wdata  = t_entry'({1'b1, w_entry.link});
                            n_head       = w_entry.link;
                            n_count      = r_count + t_link'(1);
                            n_rsp_handle = HOUT_W'(r_head);
                        end
                    end else if (r_range) begin
                        n_rsp_status = ST_RANGE;
                    end else if (!w_entry.in_use) begin
                        n_rsp_status = ST_NOT_USED;
                    end else begin
                        w_mem.we    = 1'b1;
                        w_mem.waddr = r_raddr;
                        w_mem.wdata = t_entry'({1'b0, r_head});
                        n_head      = t_link'(r_raddr);
                        n_count     = r_count - t_link'(1);
                    end
                    n_rsp_count = CNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
            r_written   <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            if (w_mem.we) begin
                r_written[w_mem.waddr] <= 1'b1;
            end
        end
        r_rsp_handle <= n_rsp_handle;
        r_rsp_status <= n_rsp_status;
        r_rsp_count  <= n_rsp_count;
        r_op         <= n_op;
        r_range      <= n_range;
        r_raddr      <= n_raddr;
        if (w_mem.re) begin
            r_vld <= r_written[w_mem.raddr];
        end
    end

    assign o_mem            = w_mem;
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.handle_out = r_rsp_handle;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.used_count = r_rsp_count;

    `HFLA_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= t_link'(POOL_SIZE))
    `HFLA_ASSERT_IMPL(a_write_in_exec, i_clk, i_rst_n, w_mem.we, r_state == S_EXEC)
    `HFLA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_EXEC)
    `HFLA_ASSERT_NEXT(a_alloc_count, i_clk, i_rst_n, w_mem.we && r_op == OP_ALLOC, r_count == $past(r_count) + t_link'(1))
endmodule
